// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the moving average RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Concurrent check sampled on clk and switched off while rst is high.
`define WMA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Concurrent check that stays active through reset.
`define WMA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WMA_ASSERT(label, clk, rst, prop, msg)
`define WMA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/wma_pkg.sv =====
// Shared types and constants of the windowed moving average block.
// Used by the controller, the datapath and the top level; no dependencies.
package wma_pkg;

  // Width and reset value of the window length register.
  localparam int unsigned WL_WIDTH = 7;
  localparam logic [WL_WIDTH-1:0] WL_RESET = 7'd30;

  // Commands from the controller to the datapath, one per sequencer step.
  typedef struct packed {
    logic accept;
    logic read;
    logic update;
    logic load;
    logic shift;
    logic finish;
  } wma_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic div_last;
  } wma_status_t;

endpackage

// ===== hdl/wma_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module wma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/wma_ctrl.sv =====
// Sequencer of the moving average: steps one sample through read, update,
// load, divide and finish. Depends on wma_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wma_ctrl import wma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output wma_cmd_t    cmd,
  input  wma_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state;
  logic   result_free;

  // The result register can take a new beat once the old one is gone.
  assign result_free = !out_valid || out_ready;
  assign in_ready    = (state == ST_IDLE);

  // Commands decoded from the current state.
  always_comb begin
    cmd        = '0;
    cmd.accept = in_valid && (state == ST_IDLE);
    cmd.read   = (state == ST_READ);
    cmd.update = (state == ST_UPDATE);
    cmd.load   = (state == ST_LOAD);
    cmd.shift  = (state == ST_DIVIDE);
    cmd.finish = (state == ST_FINISH) && result_free;
  end

  // State register and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The flag rises when a result is loaded and falls once it is taken.
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_READ;
          end
        end
        ST_READ:   state <= ST_UPDATE;
        ST_UPDATE: state <= ST_LOAD;
        ST_LOAD:   state <= ST_DIVIDE;
        ST_DIVIDE: begin
          if (status.div_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (result_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `WMA_ASSERT(a_accept_starts_read, clk, rst, cmd.accept |=> state == ST_READ, "accepted beat did not start a read")
  `WMA_ASSERT(a_finish_sets_valid, clk, rst, cmd.finish |=> out_valid && state == ST_IDLE, "finished result not presented")
  `WMA_ASSERT(a_divide_ends, clk, rst, (state == ST_DIVIDE) && status.div_last |=> state == ST_FINISH, "divider end missed")

endmodule

// ===== hdl/wma_datapath.sv =====
// Datapath of the moving average: window length register, sample ring,
// running sum, ring position and a serial restoring divider.
// Depends on wma_pkg, wma_ram and assert_macros.svh.
`include "assert_macros.svh"

module wma_datapath import wma_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [WL_WIDTH-1:0]            cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wma_cmd_t                       cmd,
  output wma_status_t                    status,
  output logic signed [SAMPLE_WIDTH-1:0] mean,
  output logic                           window_full
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int DIV_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_WIDTH + IDX_W;
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int CMP_W = (DIV_W > WL_WIDTH) ? DIV_W : WL_WIDTH;

  logic [WL_WIDTH-1:0]     wl;
  logic [CMP_W-1:0]        wl_ext;
  logic [DIV_W-1:0]        len;
  logic [DIV_W-1:0]        len_q;
  logic [DIV_W-1:0]        pos;
  logic                    filled;
  logic                    warm;
  logic [IDX_W-1:0]        addr;
  logic [SAMPLE_WIDTH-1:0] sample_q;
  logic [SAMPLE_WIDTH-1:0] old_sample;
  logic [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]        old_ext;
  logic [SUM_W-1:0]        new_ext;
  logic [DIV_W-1:0]        count_after;
  logic [DIV_W-1:0]        divisor_next;
  logic                    full_q;
  logic                    neg;
  logic [SUM_W-1:0]        dq;
  logic [DIV_W:0]          rem;
  logic [DIV_W:0]          rem_sh;
  logic [DIV_W:0]          div_ext;
  logic                    ge;
  logic [DIV_W-1:0]        div;
  logic [CNT_W-1:0]        cnt;
  logic                    sat_pos;
  logic                    sat_neg;

  // Window length as used: zero acts as one, large values clamp to the ring.
  assign wl_ext = CMP_W'(wl);
  always_comb begin
    if (wl_ext == '0) begin
      len = DIV_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      len = DIV_W'(MAX_WINDOW);
    end else begin
      len = DIV_W'(wl_ext);
    end
  end

  // Sample ring; the old entry is read in the cycle before it is replaced.
  wma_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (cmd.update),
    .wr_addr(addr),
    .wr_data(sample_q),
    .rd_en  (cmd.read),
    .rd_addr(addr),
    .rd_data(old_sample)
  );

  // Sign extension of the outgoing and incoming samples; warm-up drops nothing.
  assign old_ext = warm ? '0 :
                   {{(SUM_W - SAMPLE_WIDTH){old_sample[SAMPLE_WIDTH-1]}}, old_sample};
  assign new_ext = {{(SUM_W - SAMPLE_WIDTH){sample_q[SAMPLE_WIDTH-1]}}, sample_q};
  assign count_after  = DIV_W'(addr) + DIV_W'(1);
  assign divisor_next = warm ? count_after : len_q;

  // One restoring divider step: shift in the next dividend bit, try subtract.
  assign div_ext = {1'b0, div};
  assign rem_sh  = {rem[DIV_W-1:0], dq[SUM_W-1]};
  assign ge      = (rem_sh >= div_ext);
  assign status.div_last = (cnt == CNT_W'(1));

  // Saturation of the quotient magnitude to the signed sample range.
  assign sat_pos = |dq[SUM_W-1:SAMPLE_WIDTH-1];
  assign sat_neg = (|dq[SUM_W-1:SAMPLE_WIDTH]) ||
                   (dq[SAMPLE_WIDTH-1] && (|dq[SAMPLE_WIDTH-2:0]));

  // Architectural state: window length, ring position, fill flag, sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      wl     <= WL_RESET;
      pos    <= '0;
      filled <= 1'b0;
      sum    <= '0;
    end else begin
      if (cfg_we) begin
        wl <= cfg_data;
      end
      if (cmd.update) begin
        sum <= sum - old_ext + new_ext;
        pos <= count_after;
        if (!warm) begin
          filled <= 1'b1;
        end
      end
    end
  end

  // Per-beat working registers and the divider.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= sample;
      len_q    <= len;
      warm     <= !filled && (pos < len);
      addr     <= (pos >= len) ? '0 : IDX_W'(pos);
    end
    if (cmd.update) begin
      div    <= divisor_next;
      full_q <= (divisor_next == len_q);
    end
    if (cmd.load) begin
      neg <= sum[SUM_W-1];
      dq  <= sum[SUM_W-1] ? -sum : sum;
      rem <= '0;
      cnt <= CNT_W'(SUM_W);
    end
    if (cmd.shift) begin
      rem <= ge ? (rem_sh - div_ext) : rem_sh;
      dq  <= {dq[SUM_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.finish) begin
      window_full <= full_q;
      if (neg) begin
        mean <= sat_neg ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : -dq[SAMPLE_WIDTH-1:0];
      end else begin
        mean <= sat_pos ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} : dq[SAMPLE_WIDTH-1:0];
      end
    end
  end

  `WMA_ASSERT(a_pos_in_ring, clk, rst, pos <= DIV_W'(MAX_WINDOW), "ring position beyond the ring")
  `WMA_ASSERT(a_rem_below_div, clk, rst, cmd.shift |-> rem < div_ext, "divider remainder not reduced")
  `WMA_ASSERT_ALWAYS(a_filled_sticky, clk, $fell(filled) |-> $past(rst), "fill flag cleared outside reset")

endmodule

// ===== hdl/windowed_moving_average.sv =====
// Top level of the windowed moving average: controller plus datapath.
// Depends on wma_pkg, wma_ctrl, wma_datapath and wma_ram.
//
// Usage: one signed sample beat comes in on in_valid/in_ready and one mean
// beat goes out on out_valid/out_ready for every sample. The mean is the sum
// of the stored samples divided by the sample count during warm-up and by
// the window length once the ring has filled, truncated toward zero;
// window_full is high when the divisor equals the window length.
// The window length register is written through cfg_valid/cfg_ready
// (always ready) and should only change while the block is idle.
// An accepted sample passes through READ, UPDATE, LOAD, DIVIDE and FINISH,
// and out_valid rises as FINISH loads the result. The serial divider works on
// SUM_W = SAMPLE_WIDTH + clog2(MAX_WINDOW) bits (38 at the defaults) and
// retires one quotient bit a cycle, so one sample is in flight at a time.
// Reset clears the running sum, ring position and fill flag and loads a
// window length of 30; the ring itself needs no clearing pass.
// A stalled receiver holds the result in the output register; the next
// sample is still accepted and processed, and waits at the end if needed.
module windowed_moving_average import wma_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [WL_WIDTH-1:0]            window_length,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] mean,
  output logic                           window_full
);

  wma_cmd_t    cmd;
  wma_status_t status;

  // The register port takes a write in any cycle.
  assign cfg_ready = 1'b1;

  wma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .status   (status)
  );

  wma_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (window_length),
    .sample     (sample),
    .cmd        (cmd),
    .status     (status),
    .mean       (mean),
    .window_full(window_full)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for windowed_moving_average: sample beats in, mean beats out.
// Depends on wma_pkg and the RTL under hdl; it needs no other files and reads no input.
module tb;
  import wma_pkg::*;

  localparam int SAMPLE_W = 32;
  localparam int RING_DEPTH = 64;
  localparam int RING_IDX_W = $clog2(RING_DEPTH);
  localparam int SUM_W = 38;
  localparam int TOTAL_SAMPLES = 1050;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic                       full;
  } avg_result_t;

  typedef enum {MIX_FULL, MIX_HIGH, MIX_LOW, MIX_SMALL, MIX_EDGE} sample_mix_t;
  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [WL_WIDTH-1:0]        window_length;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] mean;
  logic                       window_full;

  // Samples waiting to be driven, and averages waiting to come out.
  logic signed [SAMPLE_W-1:0] sample_backlog[$];
  avg_result_t                avg_expected[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int items_queued = 0;

  // Shadow of the averaging state, kept in step with accepted beats.
  logic signed [SAMPLE_W-1:0] ring_shadow[RING_DEPTH];
  logic [SUM_W-1:0]           sum_shadow;
  logic [WL_WIDTH-1:0]        pos_shadow;
  logic                       filled_shadow;
  logic [WL_WIDTH-1:0]        window_shadow;
  int                         ring_top;

  windowed_moving_average u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .window_length (window_length),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mean          (mean),
    .window_full   (window_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // A window length of zero behaves as one; anything past the ring depth is clipped.
  function automatic int eff_window(input logic [WL_WIDTH-1:0] v);
    if (v == 0) return 1;
    if (v > RING_DEPTH) return RING_DEPTH;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Advance the shadow state by one sample and work out the average it yields.
  task automatic advance_average(input logic signed [SAMPLE_W-1:0] s,
                                 output avg_result_t res);
    int                         len;
    int                         divisor;
    logic signed [SAMPLE_W-1:0] old;
    longint                     sum64;
    longint                     quot;
    len = eff_window(window_shadow);
    if (!filled_shadow && pos_shadow < len) begin
      // Warm-up: append and divide by the count so far.
      ring_shadow[pos_shadow[RING_IDX_W-1:0]] = s;
      sum_shadow = sum_shadow + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
      if (int'(pos_shadow) + 1 > ring_top) ring_top = int'(pos_shadow) + 1;
      pos_shadow = pos_shadow + 1'b1;
      divisor = int'(pos_shadow);
    end else begin
      // Filled ring: swap the oldest sample for the new one.
      filled_shadow = 1'b1;
      if (pos_shadow >= len) pos_shadow = '0;
      old = ring_shadow[pos_shadow[RING_IDX_W-1:0]];
      sum_shadow = sum_shadow - {{(SUM_W-SAMPLE_W){old[SAMPLE_W-1]}}, old};
      ring_shadow[pos_shadow[RING_IDX_W-1:0]] = s;
      sum_shadow = sum_shadow + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
      pos_shadow = pos_shadow + 1'b1;
      divisor = len;
    end
    sum64 = longint'($signed(sum_shadow));
    quot = sum64 / longint'(divisor);
    if (quot > 64'sd2147483647) quot = 64'sd2147483647;
    if (quot < -64'sd2147483648) quot = -64'sd2147483648;
    res.mean = quot[SAMPLE_W-1:0];
    res.full = (divisor == len);
  endtask

  // Driver: presents the next queued sample, holding it until the beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        sample <= sample_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: tracks register writes and accepted samples, checks each mean beat.
  always @(posedge clk) begin
    avg_result_t res;
    avg_result_t want;
    if (rst) begin
      sum_shadow = '0;
      pos_shadow = '0;
      filled_shadow = 1'b0;
      window_shadow = WL_RESET;
      ring_top = 0;
      out_ready <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) window_shadow = window_length;
      if (in_valid && in_ready) begin
        advance_average(sample, res);
        avg_expected.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (avg_expected.size() == 0) begin
          report_mismatch($sformatf("mean beat %0h with nothing outstanding", mean));
        end else begin
          want = avg_expected.pop_front();
          if (mean !== want.mean)
            report_mismatch($sformatf("mean got %0h expected %0h", mean, want.mean));
          if (window_full !== want.full)
            report_mismatch($sformatf("window_full got %b expected %b",
                                      window_full, want.full));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(input sample_mix_t mix);
    case (mix)
      MIX_HIGH:  return 32'sh7FFF_FFFF - $urandom_range(0, 65535);
      MIX_LOW:   return 32'sh8000_0000 + $urandom_range(0, 65535);
      MIX_SMALL: return $signed($urandom_range(0, 1 << 19)) - 32'sd262144;
      MIX_EDGE: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          4: return 32'sd1;
          default: return $urandom;
        endcase
      end
      default:   return $urandom;
    endcase
  endfunction

  // Extremes come up often; raising the window past the written part of a filled
  // ring would subtract entries that were never stored, so such lengths are redrawn.
  function automatic logic [WL_WIDTH-1:0] pick_window();
    logic [WL_WIDTH-1:0] v;
    do begin
      case ($urandom_range(0, 5))
        0: v = WL_WIDTH'(0);
        1: v = WL_WIDTH'(1);
        2: v = WL_WIDTH'(RING_DEPTH);
        3: v = WL_WIDTH'($urandom_range(RING_DEPTH + 1, 127));
        4: v = WL_WIDTH'($urandom_range(2, RING_DEPTH - 1));
        default: v = WL_WIDTH'($urandom_range(0, 127));
      endcase
    end while (filled_shadow && eff_window(v) > ring_top);
    return v;
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SEND) ? 65 : (mode == IDLE_BOTH) ? 37 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 65 : (mode == IDLE_BOTH) ? 37 : 0;
  endtask

  // Returns at a falling edge once every sample is in and every mean is out.
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_valid || avg_expected.size() != 0);
  endtask

  // The block is idle whenever this is called, so the write cannot race a sample.
  task automatic write_window(input logic [WL_WIDTH-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    window_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic feed(input logic signed [SAMPLE_W-1:0] v);
    sample_backlog.push_back(v);
    items_queued++;
  endtask

  task automatic run_batch(input int n, input sample_mix_t mix, input idle_mode_t mode);
    set_idle(mode);
    for (int i = 0; i < n; i++) feed(draw_sample(mix));
    wait_drained();
  endtask

  initial begin
    int phase;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    window_length <= WL_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Warm-up at the reset window length with the extreme sample values.
    set_idle(IDLE_NONE);
    feed(32'sh7FFF_FFFF);
    feed(32'sh8000_0000);
    feed(32'sd0);
    feed(-32'sd1);
    feed(32'sd1);
    feed(32'sh5555_5555);
    wait_drained();

    // Raise to an out-of-range length mid warm-up and fill the whole ring high.
    write_window(7'd127);
    run_batch(RING_DEPTH - 6, MIX_HIGH, IDLE_SEND);

    // Window of one on a huge sum: the ring wraps and the mean saturates high.
    write_window(7'd0);
    set_idle(IDLE_NONE);
    feed(32'sh7FFF_FFFF);
    feed(32'sh8000_0000);
    feed(32'sd0);
    feed(-32'sd1);
    wait_drained();
    write_window(7'd64);
    feed(32'sh8000_0000);
    feed(32'sh7FFF_FFFF);
    wait_drained();
    write_window(7'd65);
    feed(32'sd1);
    wait_drained();

    // Refill the full window low, then shrink it so the mean saturates low.
    write_window(7'd64);
    run_batch(RING_DEPTH, MIX_LOW, IDLE_RECV);
    write_window(7'd1);
    set_idle(IDLE_NONE);
    feed(32'sh8000_0000);
    feed(32'sd0);
    feed(32'sh7FFF_FFFF);
    wait_drained();
    write_window(7'd2);
    feed(-32'sd1);
    feed(32'sh8000_0000);
    wait_drained();

    // Random phases, each under its own handshake pressure; most first write a newly picked window length.
    phase = 0;
    while (items_queued < TOTAL_SAMPLES) begin
      if ($urandom_range(0, 3) != 0) write_window(pick_window());
      run_batch($urandom_range(4, 60), sample_mix_t'($urandom_range(0, 4)),
                idle_mode_t'(phase % 4));
      phase++;
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0 && avg_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/wma_pkg.sv
hdl/wma_ram.sv
hdl/wma_ctrl.sv
hdl/wma_datapath.sv
hdl/windowed_moving_average.sv
dv/tb.sv
